// ===== hdl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: heap geometry, status codes,
// block header layout and the transaction structs of the ports.
// Used by first_fit_heap_allocator; no dependencies.
package ffha_pkg;

  // heap geometry
  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 8;
  localparam int ADDR_W       = $clog2(HEAP_BYTES);
  localparam int SIZE_W       = ADDR_W;
  localparam int ENTRY_W      = SIZE_W + 2;
  // wide enough for offset plus header plus size, and for header plus request
  localparam int SUM_W        = ADDR_W + 2;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_NO_SPACE = 3'd1;
  localparam logic [2:0] STATUS_NOT_ALLOC = 3'd2;
  localparam logic [2:0] STATUS_DOUBLE   = 3'd3;
  localparam logic [2:0] STATUS_RANGE    = 3'd4;

  // block header as kept in the header memory
  typedef struct packed {
    logic              start;
    logic              free;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  // request transaction
  typedef struct packed {
    logic        req_type;
    logic [12:0] alloc_size;
    logic [12:0] free_addr;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [11:0] block_addr;
    logic [2:0]  status;
  } res_t;

endpackage

// ===== hdl/ffha_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [WIDTH-1:0]              wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap allocator top level: sequencer around one header memory.
// Depends on ffha_pkg and ffha_ram.
//
// Block headers live in a 4096-entry header memory with one read and one write
// port. After reset a clearing pass writes every entry to zero with busy high.
// A request is taken when start is high and busy is low; one result follows on
// res_o with done_o high for exactly one cycle, in the cycle that busy falls (a
// free of an out-of-range offset answers in the cycle after it is taken). An
// allocate reads block headers from offset zero, one per cycle, until the
// first fit (up to HEAP_BYTES/HEADER_BYTES = 512 headers), then shrinks the hit
// block and writes the remainder header; a failed allocate scans every header.
// A free that is refused answers once its header is read. A free that succeeds
// marks the block free and runs a coalescing pass, which always walks the whole
// heap, reading one header per cycle, and writes back the held block when the
// walk ends on a merge. The result cannot be held off, and a new request may be
// taken in the same cycle that the previous result is shown.
module first_fit_heap_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ffha_pkg::req_t req_i,
  output logic          done_o,
  output ffha_pkg::res_t res_o
);

  localparam int AW = ffha_pkg::ADDR_W;
  localparam int SW = ffha_pkg::SIZE_W;
  localparam int XW = ffha_pkg::SUM_W;

  // sequencer states
  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_A_START = 4'd2;
  localparam logic [3:0] ST_A_CHK   = 4'd3;
  localparam logic [3:0] ST_A_SPLIT = 4'd4;
  localparam logic [3:0] ST_F_CHK   = 4'd5;
  localparam logic [3:0] ST_C_START = 4'd6;
  localparam logic [3:0] ST_C_HEAD  = 4'd7;
  localparam logic [3:0] ST_C_NEXT  = 4'd8;
  localparam logic [3:0] ST_C_FLUSH = 4'd9;

  logic [3:0]     state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic           ready_q, ready_d;
  logic [12:0]    size_q, size_d;
  logic [AW-1:0]  pos_q, pos_d;
  logic [AW-1:0]  nxt_q, nxt_d;
  ffha_pkg::hdr_t cur_q, cur_d;
  logic           dirty_q, dirty_d;
  logic           done_q, done_d;
  ffha_pkg::res_t res_q, res_d;

  // header memory ports
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  ffha_pkg::hdr_t                mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [ffha_pkg::ENTRY_W-1:0]  mem_rdata;
  ffha_pkg::hdr_t                rd_hdr;

  // datapath terms
  logic [XW-1:0] scan_next;
  logic [XW-1:0] walk_next;
  logic [XW-1:0] fit_need;
  logic          fit;
  logic [XW-1:0] split_pos;
  logic [SW-1:0] split_rest;
  logic [SW-1:0] merge_size;
  logic          can_merge;
  logic [XW-1:0] heap_end;

  ffha_ram #(
    .WIDTH(ffha_pkg::ENTRY_W),
    .DEPTH(ffha_pkg::HEAP_BYTES)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign rd_hdr   = ffha_pkg::hdr_t'(mem_rdata);
  assign heap_end = XW'(ffha_pkg::HEAP_BYTES);

  // next header after the one just read at pos_q
  assign scan_next = XW'(pos_q) + XW'(ffha_pkg::HEADER_BYTES) + XW'(rd_hdr.size);
  // next header after the one just read at nxt_q; also the end of a merged run
  assign walk_next = XW'(nxt_q) + XW'(ffha_pkg::HEADER_BYTES) + XW'(rd_hdr.size);

  // first-fit test and split of the hit block
  assign fit_need   = XW'(ffha_pkg::HEADER_BYTES) + XW'(size_q);
  assign fit        = rd_hdr.free && (XW'(rd_hdr.size) >= fit_need);
  assign split_pos  = XW'(pos_q) + fit_need;
  assign split_rest = rd_hdr.size - size_q[SW-1:0] - SW'(ffha_pkg::HEADER_BYTES);

  // merge of the held free block with the free block just read
  assign can_merge  = cur_q.free && rd_hdr.free;
  assign merge_size = cur_q.size + SW'(ffha_pkg::HEADER_BYTES) + rd_hdr.size;

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    ready_d   = ready_q;
    size_d    = size_q;
    pos_d     = pos_q;
    nxt_d     = nxt_q;
    cur_d     = cur_q;
    dirty_d   = dirty_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_q)
      ST_CLEAR: begin
        // zero the header memory one entry a cycle
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (req_i.req_type == ffha_pkg::REQ_ALLOC) begin
            size_d = req_i.alloc_size;
            // first use: one free block over the whole heap
            if (!ready_q) begin
              mem_we         = 1'b1;
              mem_waddr      = '0;
              mem_wdata.start = 1'b1;
              mem_wdata.free  = 1'b1;
              mem_wdata.size  = SW'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES);
              ready_d        = 1'b1;
            end
            state_d = ST_A_START;
          end else if (XW'(req_i.free_addr) >= heap_end) begin
            done_d = 1'b1;
            res_d  = '{block_addr: '0, status: ffha_pkg::STATUS_RANGE};
          end else begin
            mem_re    = 1'b1;
            mem_raddr = req_i.free_addr[AW-1:0];
            pos_d     = req_i.free_addr[AW-1:0];
            state_d   = ST_F_CHK;
          end
        end
      end

      ST_A_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        pos_d     = '0;
        state_d   = ST_A_CHK;
      end

      ST_A_CHK: begin
        if (fit) begin
          // shrink the hit block, hold the remainder header for the next cycle
          mem_we          = 1'b1;
          mem_waddr       = pos_q;
          mem_wdata.start = 1'b1;
          mem_wdata.free  = 1'b0;
          mem_wdata.size  = size_q[SW-1:0];
          nxt_d           = split_pos[AW-1:0];
          cur_d.start     = 1'b1;
          cur_d.free      = 1'b1;
          cur_d.size      = split_rest;
          state_d         = ST_A_SPLIT;
        end else if (scan_next >= heap_end) begin
          done_d  = 1'b1;
          res_d   = '{block_addr: '0, status: ffha_pkg::STATUS_NO_SPACE};
          state_d = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = scan_next[AW-1:0];
          pos_d     = scan_next[AW-1:0];
        end
      end

      ST_A_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = nxt_q;
        mem_wdata = cur_q;
        done_d    = 1'b1;
        res_d     = '{block_addr: 12'(pos_q), status: ffha_pkg::STATUS_OK};
        state_d   = ST_IDLE;
      end

      ST_F_CHK: begin
        if (!rd_hdr.start) begin
          done_d  = 1'b1;
          res_d   = '{block_addr: '0, status: ffha_pkg::STATUS_NOT_ALLOC};
          state_d = ST_IDLE;
        end else if (rd_hdr.free) begin
          done_d  = 1'b1;
          res_d   = '{block_addr: '0, status: ffha_pkg::STATUS_DOUBLE};
          state_d = ST_IDLE;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = pos_q;
          mem_wdata      = rd_hdr;
          mem_wdata.free = 1'b1;
          state_d        = ST_C_START;
        end
      end

      ST_C_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        pos_d     = '0;
        state_d   = ST_C_HEAD;
      end

      ST_C_HEAD: begin
        // hold the first header, fetch its neighbor
        cur_d   = rd_hdr;
        dirty_d = 1'b0;
        if (scan_next >= heap_end) begin
          done_d  = 1'b1;
          res_d   = '{block_addr: '0, status: ffha_pkg::STATUS_OK};
          state_d = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = scan_next[AW-1:0];
          nxt_d     = scan_next[AW-1:0];
          state_d   = ST_C_NEXT;
        end
      end

      ST_C_NEXT: begin
        if (can_merge) begin
          // absorb the neighbor: clear its header, grow the held one
          mem_we     = 1'b1;
          mem_waddr  = nxt_q;
          cur_d.size = merge_size;
          dirty_d    = 1'b1;
          if (walk_next >= heap_end) begin
            state_d = ST_C_FLUSH;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = walk_next[AW-1:0];
            nxt_d     = walk_next[AW-1:0];
          end
        end else begin
          // write back a grown block, step to the neighbor
          if (dirty_q) begin
            mem_we    = 1'b1;
            mem_waddr = pos_q;
            mem_wdata = cur_q;
          end
          pos_d   = nxt_q;
          cur_d   = rd_hdr;
          dirty_d = 1'b0;
          if (walk_next >= heap_end) begin
            done_d  = 1'b1;
            res_d   = '{block_addr: '0, status: ffha_pkg::STATUS_OK};
            state_d = ST_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = walk_next[AW-1:0];
            nxt_d     = walk_next[AW-1:0];
          end
        end
      end

      ST_C_FLUSH: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = cur_q;
        done_d    = 1'b1;
        res_d     = '{block_addr: '0, status: ffha_pkg::STATUS_OK};
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ready_q <= 1'b0;
      dirty_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ready_q <= ready_d;
      dirty_q <= dirty_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    pos_q  <= pos_d;
    nxt_q  <= nxt_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
  end

  // an accepted request keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request neither in progress nor answered");

  // no write hits the entry being read in the same cycle
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("header memory read and write collide");

  // a failed allocation reports offset zero
  a_nospace_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == ffha_pkg::STATUS_NO_SPACE)) |-> (res_o.block_addr == '0))
    else $error("no-space result carries an offset");

  // the coalescing walk only starts once the heap exists
  a_walk_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_C_START) |-> ready_q)
    else $error("coalescing before heap set up");

endmodule
